/* rtl/text_mode_glyph_rasterizer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the text mode glyph rasterizer
// Short wrappers around concurrent assertions with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_GLYPH_RASTERIZER_ASSERT_SVH
`define TEXT_MODE_GLYPH_RASTERIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMGR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMGR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/tmgr_pkg.sv */
// ----------------------------------------------------------------------------
// tmgr_pkg
// Shared types, codes and constants of the text mode glyph rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tmgr_pkg;

   // Number of colour registers and width of the register index.
   localparam int NUM_COLOR_REGS = 5;
   localparam int CSR_INDEX_W    = 3;

   // Default depth of the queue between front and back end.
   localparam int QUEUE_DEPTH = 2;

   // Text mode codes.
   localparam logic [2:0] MODE_NONE   = 3'd0;
   localparam logic [2:0] MODE_MONO_T = 3'd1;
   localparam logic [2:0] MODE_MONO_B = 3'd2;
   localparam logic [2:0] MODE_MONO_D = 3'd3;
   localparam logic [2:0] MODE_MULTI  = 3'd4;
   localparam logic [2:0] MODE_MULTI2 = 3'd5;
   localparam logic [2:0] MODE_WIDE   = 3'd6;
   localparam logic [2:0] MODE_WIDE2  = 3'd7;

   // Character code fields and colour select limit.
   localparam logic [7:0] DESC_MARK = 8'h60;
   localparam logic [7:0] INV_LIMIT = 8'd128;
   localparam logic [7:0] SEL_LIMIT = 8'd4;

   // Colour register indexes.
   localparam logic [2:0] REG_PAIR_ONE   = 3'd1;
   localparam logic [2:0] REG_PAIR_TWO   = 3'd2;
   localparam logic [2:0] REG_BACKGROUND = 3'd3;
   localparam logic [2:0] REG_INV_PAIR   = 3'd4;

   // Multicolour pair values.
   localparam logic [1:0] PAIR_NONE  = 2'd0;
   localparam logic [1:0] PAIR_ONE   = 2'd1;
   localparam logic [1:0] PAIR_TWO   = 2'd2;
   localparam logic [1:0] PAIR_THREE = 2'd3;

   // Last row index per class.
   localparam logic [3:0] LAST_ROW_ERROR = 4'd0;
   localparam logic [3:0] LAST_ROW_PLAIN = 4'd7;
   localparam logic [3:0] LAST_ROW_DESC  = 4'd9;

   typedef logic [NUM_COLOR_REGS-1:0][7:0] color_regs_type;

   // Class of a character request after decoding.
   typedef enum logic [1:0] {
      KIND_ERROR,
      KIND_MONO,
      KIND_MULTI,
      KIND_WIDE
   } kind_type;

   // Input transaction payload.
   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  char_code;
      logic [7:0]  color;
      logic [63:0] glyph;
      logic [9:0]  pos_x;
      logic [8:0]  pos_y;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [9:0]  row_y;
      logic [9:0]  start_x;
      logic [3:0]  cell_count;
      logic [1:0]  cell_width;
      logic [1:0]  cell_height;
      logic [7:0]  write_mask;
      logic [63:0] cell_colors;
      logic        mode_error;
      logic        last_row;
   } rsp_type;

   // Decoded character waiting in the queue.
   typedef struct packed {
      kind_type    kind;
      logic        transparent;
      logic        descender;
      logic        inverse;
      logic        tall;
      logic [3:0]  last_idx;
      logic [2:0]  sel;
      logic [7:0]  fg;
      logic [63:0] glyph;
      logic [9:0]  pos_x;
      logic [8:0]  pos_y;
   } entry_type;

   // Queue status seen by both ends.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

/* rtl/tmgr_front.sv */
// ----------------------------------------------------------------------------
// tmgr_front
// Accepts character requests and decodes them into queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

module tmgr_front
   import tmgr_pkg::*;
(
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_payload,
   input  wire queue_status_type q_status,
   output logic                  q_push,
   output entry_type             q_entry
);

   // A request is taken whenever the queue has room.
   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

   // Decode the mode and character code into the row sequencing controls.
   always_comb begin
      q_entry             = '0;
      q_entry.kind        = KIND_ERROR;
      q_entry.last_idx    = LAST_ROW_ERROR;
      q_entry.inverse     = (req_payload.char_code >= INV_LIMIT);
      q_entry.fg          = req_payload.color;
      q_entry.glyph       = req_payload.glyph;
      q_entry.pos_x       = req_payload.pos_x;
      q_entry.pos_y       = req_payload.pos_y;
      q_entry.sel         = (req_payload.color > SEL_LIMIT) ? REG_INV_PAIR
                                                            : req_payload.color[2:0];
      unique case (req_payload.mode) inside
         MODE_MONO_T, MODE_MONO_B, MODE_MONO_D: begin
            q_entry.kind        = KIND_MONO;
            q_entry.transparent = (req_payload.mode == MODE_MONO_T);
            q_entry.descender   = (req_payload.mode == MODE_MONO_D) &&
               ((req_payload.char_code & DESC_MARK) == DESC_MARK);
            q_entry.last_idx    = (req_payload.mode == MODE_MONO_D) ? LAST_ROW_DESC
                                                                   : LAST_ROW_PLAIN;
         end
         MODE_MULTI, MODE_MULTI2: begin
            q_entry.kind     = KIND_MULTI;
            q_entry.tall     = (req_payload.mode == MODE_MULTI2);
            q_entry.last_idx = LAST_ROW_PLAIN;
         end
         MODE_WIDE, MODE_WIDE2: begin
            q_entry.kind     = KIND_WIDE;
            q_entry.tall     = (req_payload.mode == MODE_WIDE2);
            q_entry.last_idx = LAST_ROW_PLAIN;
         end
         MODE_NONE: begin
            q_entry.kind = KIND_ERROR;
         end
         default: begin
            q_entry.kind = KIND_ERROR;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/tmgr_queue.sv */
// ----------------------------------------------------------------------------
// tmgr_queue
// Short FIFO of decoded characters between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tmgr_queue
   import tmgr_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  push_entry,
   input  wire logic       pop,
   output entry_type       head,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type           entries_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entries_ff[rd_ptr_ff];

   // Pointer wrap and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/tmgr_back.sv */
// ----------------------------------------------------------------------------
// tmgr_back
// Walks the rows of the character at the queue head, one row per cycle while
// rsp_stall is low, and holds each row result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmgr_back
   import tmgr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire color_regs_type   color_regs,
   input  wire entry_type        head,
   input  wire queue_status_type q_status,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_payload
);

   logic [3:0] row_ff, row_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       advance, fire, last;
   logic [7:0] byte_raw, byte_row;
   logic       blank;
   logic [1:0] pair;
   logic [7:0] pair_color;

   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign fire        = advance && !q_status.empty;
   assign last        = (row_ff == head.last_idx);
   assign q_pop       = fire && last;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Row counter restarts for every character.
   always_comb begin
      row_in = row_ff;
      if (fire) begin
         row_in = last ? '0 : row_ff + 1'b1;
      end
   end

   // Build the result of the current row.
   always_comb begin
      byte_raw = head.glyph[63 - 8 * row_ff[2:0] -: 8];
      blank    = head.descender ? (row_ff < 4'd2) : (row_ff > 4'd7);
      byte_row = blank ? 8'h00 : byte_raw;
      pair       = PAIR_NONE;
      pair_color = '0;

      rsp_in             = '0;
      rsp_in.row_y       = {1'b0, head.pos_y} +
                           (head.tall ? {5'b0, row_ff, 1'b0} : {6'b0, row_ff});
      rsp_in.start_x     = head.pos_x;
      rsp_in.cell_count  = 4'd8;
      rsp_in.cell_width  = 2'd2;
      rsp_in.cell_height = head.tall ? 2'd2 : 2'd1;
      rsp_in.last_row    = last;

      case (head.kind)
         KIND_MONO: begin
            // One bit per cell, complemented for inverse codes.
            if (head.inverse) begin
               byte_row = ~byte_row;
            end
            rsp_in.cell_width = 2'd1;
            for (int x = 0; x < 8; x++) begin
               if (byte_row[7 - x]) begin
                  rsp_in.write_mask[7 - x]         = 1'b1;
                  rsp_in.cell_colors[63 - 8*x -: 8] = head.fg;
               end else if (!head.transparent) begin
                  rsp_in.write_mask[7 - x]         = 1'b1;
                  rsp_in.cell_colors[63 - 8*x -: 8] = color_regs[REG_BACKGROUND];
               end
            end
         end
         KIND_MULTI: begin
            // Two bits per cell; pair value zero is not drawn.
            rsp_in.cell_count = 4'd4;
            for (int x = 0; x < 4; x++) begin
               pair = byte_row[7 - 2*x -: 2];
               case (pair)
                  PAIR_ONE:   pair_color = color_regs[REG_PAIR_ONE];
                  PAIR_TWO:   pair_color = color_regs[REG_PAIR_TWO];
                  PAIR_THREE: pair_color = head.inverse ? color_regs[REG_INV_PAIR]
                                                        : color_regs[REG_BACKGROUND];
                  default:    pair_color = '0;
               endcase
               rsp_in.write_mask[7 - x]          = (pair != PAIR_NONE);
               rsp_in.cell_colors[63 - 8*x -: 8] = pair_color;
            end
         end
         KIND_WIDE: begin
            // Set bits draw in the selected colour register.
            rsp_in.write_mask = byte_row;
            for (int x = 0; x < 8; x++) begin
               if (byte_row[7 - x]) begin
                  rsp_in.cell_colors[63 - 8*x -: 8] = color_regs[head.sel];
               end
            end
         end
         default: begin
            // Unsupported mode: a single empty error row.
            rsp_in.row_y       = {1'b0, head.pos_y};
            rsp_in.cell_count  = '0;
            rsp_in.cell_width  = 2'd1;
            rsp_in.cell_height = 2'd1;
            rsp_in.mode_error  = 1'b1;
            rsp_in.last_row    = 1'b1;
         end
      endcase
   end

   // Output register is reloaded whenever it is empty or being taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/text_mode_glyph_rasterizer.sv */
// ----------------------------------------------------------------------------
// text_mode_glyph_rasterizer
// Top level: colour registers, request decoder, queue and row generator.
// ----------------------------------------------------------------------------
// Each character request produces one result transaction per displayed row,
// issued one per clock by the row generator while rsp_stall is low: ten rows
// for mode 3, eight for modes 1, 2 and 4 to 7, one for an unsupported mode.
// The row generator's single row per cycle sets the sustained rate. A queue
// of QUEUE_DEPTH decoded characters sits between the request side and the
// row generator, so new requests are taken while earlier rows are still being
// produced; rows are held in an output register after the queue. Colour
// registers are written through the csr_ port, which never waits.
`default_nettype none

`include "text_mode_glyph_rasterizer_assert.svh"

module text_mode_glyph_rasterizer
   import tmgr_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_payload,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_data
);

   color_regs_type   color_reg_ff;
   logic             q_push, q_pop;
   entry_type        q_entry, q_head;
   queue_status_type q_status;

   // Colour register writes; indexes past the last register are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_reg_ff <= '0;
      end else if (csr_valid && csr_ready &&
                   (csr_index < CSR_INDEX_W'(NUM_COLOR_REGS))) begin
         color_reg_ff[csr_index] <= csr_data;
      end
   end

   tmgr_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   tmgr_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   tmgr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .color_regs  (color_reg_ff),
      .head        (q_head),
      .q_status    (q_status),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // An error transaction always closes its character.
   `TMGR_ASSERT_SAME(a_error_is_last, clock, reset, rsp_valid && rsp_payload.mode_error, rsp_payload.last_row, "error result without last_row")

   // Multicolour rows never enable the unused low cells.
   `TMGR_ASSERT_SAME(a_multi_low_cells, clock, reset, rsp_valid && (rsp_payload.cell_count == 4'd4), (rsp_payload.write_mask[3:0] == 4'h0) && (rsp_payload.cell_colors[31:0] == 32'h0), "multicolour row drives unused cells")

   // A pop leaves the queue with room for the next request.
   `TMGR_ASSERT_NEXT(a_pop_frees_slot, clock, reset, q_pop && !q_push, !q_status.full, "queue still full after pop")

endmodule

`default_nettype wire
